@@ hw/rtl/bu2x_pkg.sv @@
// ----------------------------------------------------------------------------
// bu2x_pkg
// Shared constants and types of the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
package bu2x_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int DIM_W   = 11;
	localparam int COORD_W = 11;
	localparam int PIX_W   = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// result kinds, in emission order
	typedef enum logic [1:0] {
		KIND_CENTER = 2'd0,
		KIND_VERT   = 2'd1,
		KIND_HORIZ  = 2'd2,
		KIND_ORIG   = 2'd3
	} kind_t;

	localparam int NUM_KINDS = 4;

	// accepted request on its way to the interpolation stage
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] pixel;
	} item_t;

	// interpolated values of one request
	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		logic [NUM_KINDS-1:0] mask;
		logic [PIX_W-1:0]     v_center;
		logic [PIX_W-1:0]     v_vert;
		logic [PIX_W-1:0]     v_horiz;
		logic [PIX_W-1:0]     v_orig;
	} interp_t;

endpackage

@@ hw/rtl/bu2x_line_buf.sv @@
// ----------------------------------------------------------------------------
// bu2x_line_buf
// Previous-row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bu2x_line_buf
	import bu2x_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output logic [PIX_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [PIX_W-1:0] wr_data
);

	logic [PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/bu2x_interp.sv @@
// ----------------------------------------------------------------------------
// bu2x_interp
// Interpolation stage: merges line-buffer data with forwarding, computes the
// four candidate values and writes the current pixel back to the line buffer.
// ----------------------------------------------------------------------------
module bu2x_interp
	import bu2x_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  item_t            acc_item,
	input  logic [PIX_W-1:0] rd_data,
	input  logic             emit_free,
	output logic             busy,
	output logic             adv,
	output interp_t          result,
	output logic             wr_en,
	output logic [COL_W-1:0] wr_addr,
	output logic [PIX_W-1:0] wr_data
);

	item_t            item_s1;
	logic             valid_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_pix_s1;
	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] up_left_q;
	logic [PIX_W-1:0] up;
	logic             have_up;
	logic             have_left;
	logic [PIX_W+1:0] sum4;
	logic [PIX_W:0]   sum_v;
	logic [PIX_W:0]   sum_h;

	assign adv  = valid_s1 & emit_free;
	assign busy = valid_s1 & ~emit_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			left_q    <= '0;
			up_left_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				left_q    <= item_s1.pixel;
				up_left_q <= up;
			end
		end
	end

	// forward the write that lands on the same edge as the read
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= acc_item;
			fwd_s1     <= adv && (item_s1.col == acc_item.col);
			fwd_pix_s1 <= item_s1.pixel;
		end
	end

	always_comb begin
		up        = fwd_s1 ? fwd_pix_s1 : rd_data;
		have_up   = (item_s1.row != '0);
		have_left = (item_s1.col != '0);
		sum4  = (PIX_W+2)'(up_left_q) + (PIX_W+2)'(up) + (PIX_W+2)'(left_q)
		      + (PIX_W+2)'(item_s1.pixel) + (PIX_W+2)'(2);
		sum_v = (PIX_W+1)'(up) + (PIX_W+1)'(item_s1.pixel) + (PIX_W+1)'(1);
		sum_h = (PIX_W+1)'(left_q) + (PIX_W+1)'(item_s1.pixel) + (PIX_W+1)'(1);

		result.row  = item_s1.row;
		result.col  = item_s1.col;
		result.mask = '0;
		result.mask[KIND_CENTER] = have_up & have_left;
		result.mask[KIND_VERT]   = have_up;
		result.mask[KIND_HORIZ]  = have_left;
		result.mask[KIND_ORIG]   = 1'b1;
		result.v_center = sum4[PIX_W+1:2];
		result.v_vert   = sum_v[PIX_W:1];
		result.v_horiz  = sum_h[PIX_W:1];
		result.v_orig   = item_s1.pixel;
	end

	assign wr_en   = adv;
	assign wr_addr = item_s1.col;
	assign wr_data = item_s1.pixel;

endmodule

@@ hw/rtl/bu2x_emit.sv @@
// ----------------------------------------------------------------------------
// bu2x_emit
// Output stage: holds one request's values and sends its results one per
// cycle while res_stall is low, centre, vertical, horizontal, original.
// ----------------------------------------------------------------------------
module bu2x_emit
	import bu2x_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  interp_t            load_data,
	output logic               free,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_col,
	output logic [PIX_W-1:0]   out_value,
	output logic               run_last
);

	interp_t              hold_q;
	logic [NUM_KINDS-1:0] mask_q;
	logic [NUM_KINDS-1:0] sel;
	logic [NUM_KINDS-1:0] remain;
	logic                 take;
	logic [COORD_W-1:0]   row2;
	logic [COORD_W-1:0]   col2;

	always_comb begin
		sel = '0;
		priority if (mask_q[KIND_CENTER]) begin
			sel[KIND_CENTER] = 1'b1;
		end else if (mask_q[KIND_VERT]) begin
			sel[KIND_VERT] = 1'b1;
		end else if (mask_q[KIND_HORIZ]) begin
			sel[KIND_HORIZ] = 1'b1;
		end else if (mask_q[KIND_ORIG]) begin
			sel[KIND_ORIG] = 1'b1;
		end else begin
			sel = '0;
		end
	end

	assign res_valid = |mask_q;
	assign take      = res_valid & ~res_stall;
	assign remain    = mask_q & ~sel;
	assign free      = ~res_valid | (take & (remain == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= load_data.mask;
		end else if (take) begin
			mask_q <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hold_q <= load_data;
		end
	end

	always_comb begin
		row2 = COORD_W'({hold_q.row, 1'b0});
		col2 = COORD_W'({hold_q.col, 1'b0});
		out_row   = row2;
		out_col   = col2;
		out_value = hold_q.v_orig;
		run_last  = sel[KIND_ORIG];
		priority if (sel[KIND_CENTER]) begin
			out_row   = row2 - COORD_W'(1);
			out_col   = col2 - COORD_W'(1);
			out_value = hold_q.v_center;
		end else if (sel[KIND_VERT]) begin
			out_row   = row2 - COORD_W'(1);
			out_value = hold_q.v_vert;
		end else if (sel[KIND_HORIZ]) begin
			out_col   = col2 - COORD_W'(1);
			out_value = hold_q.v_horiz;
		end else begin
			out_value = hold_q.v_orig;
		end
	end

endmodule

@@ hw/rtl/bilinear_upscale_2x_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_upscale_2x_unit
// Streaming 2x bilinear upscaler for 8-bit grey images with a one-row line
// buffer in block memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// pix      in         pix_valid/stall    pixel_value
// res      out        res_valid/stall    out_row, out_col, out_value, run_last
// cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// A request produces 1 to 4 result pixels, and the result channel sets the
// rate. The first result passes the line-buffer read register, then the
// output-stage hold register, which it enters once that stage is free.
// Reset clears counters and neighbour pixels; the line buffer is not
// cleared. A stalled result channel holds the output stage, then the
// interpolation stage, then raises pix_stall.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x_unit
	import bu2x_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  logic [PIX_W-1:0]     pixel_value,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [COORD_W-1:0]   out_row,
	output logic [COORD_W-1:0]   out_col,
	output logic [PIX_W-1:0]     out_value,
	output logic                 run_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             accept;
	logic             busy;
	logic             adv;
	logic             emit_free;
	item_t            acc_item;
	interp_t          result;
	logic [PIX_W-1:0] rd_data;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	logic [PIX_W-1:0] wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(MAX_WIDTH);
			image_height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (image_width_q == '0) begin
			width_eff = DIM_W'(1);
		end else if (image_width_q > DIM_W'(MAX_WIDTH)) begin
			width_eff = DIM_W'(MAX_WIDTH);
		end else begin
			width_eff = image_width_q;
		end
		if (image_height_q == '0) begin
			height_eff = DIM_W'(1);
		end else if (image_height_q > DIM_W'(MAX_HEIGHT)) begin
			height_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			height_eff = image_height_q;
		end
	end

	assign pix_stall = busy;
	assign accept    = pix_valid & ~pix_stall;
	assign col_inc   = DIM_W'(col_q) + DIM_W'(1);
	assign row_inc   = DIM_W'(row_q) + DIM_W'(1);

	// advance raster position; wrap at line and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= width_eff) begin
				col_q <= '0;
				if (row_inc >= height_eff) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[ROW_W-1:0];
				end
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_comb begin
		acc_item.row   = row_q;
		acc_item.col   = col_q;
		acc_item.pixel = pixel_value;
	end

	bu2x_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bu2x_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.acc_item  (acc_item),
		.rd_data   (rd_data),
		.emit_free (emit_free),
		.busy      (busy),
		.adv       (adv),
		.result    (result),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	bu2x_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.load_data (result),
		.free      (emit_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.run_last  (run_last)
	);

endmodule

@@ tb/sv/bu2x_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bu2x_checker
// Watches the pixel, result and register channels of the 2x upscaler, keeps
// its own copy of the line buffer, neighbours and counters, and compares every
// output pixel with the oldest predicted one.
// ----------------------------------------------------------------------------
module bu2x_checker
	import bu2x_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_stall,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic [COORD_W-1:0]   out_row,
	input  logic [COORD_W-1:0]   out_col,
	input  logic [PIX_W-1:0]     out_value,
	input  logic                 run_last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output int                   pending,
	output int                   fail_count,
	output int                   zoomed_seen
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   value;
		logic               last;
	} zoom_px_t;

	zoom_px_t zoom_q[$];

	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [PIX_W-1:0] row_mem [MAX_WIDTH];
	logic [PIX_W-1:0] left_px;
	logic [PIX_W-1:0] diag_px;
	logic [ROW_W-1:0] row_pos;
	logic [COL_W-1:0] col_pos;

	function automatic logic [DIM_W-1:0] bound_dim(logic [DIM_W-1:0] v, int unsigned maxv);
		if (v == '0)
			return DIM_W'(1);
		if (32'(v) > maxv)
			return DIM_W'(maxv);
		return v;
	endfunction

	task automatic upscale_pixel(logic [PIX_W-1:0] cur);
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [PIX_W-1:0]   up;
		logic [COORD_W-1:0] r2;
		logic [COORD_W-1:0] c2;
		logic [PIX_W+1:0]   quad_sum;
		logic [PIX_W:0]     pair_sum;
		logic [COL_W:0]     c_next;
		logic [ROW_W:0]     r_next;
		w = bound_dim(width_reg, MAX_WIDTH);
		h = bound_dim(height_reg, MAX_HEIGHT);
		up = row_mem[col_pos];
		r2 = COORD_W'({row_pos, 1'b0});
		c2 = COORD_W'({col_pos, 1'b0});
		if (row_pos != '0 && col_pos != '0) begin
			quad_sum = (PIX_W+2)'(diag_px) + (PIX_W+2)'(up) + (PIX_W+2)'(left_px)
				+ (PIX_W+2)'(cur) + (PIX_W+2)'(2);
			zoom_q.push_back('{r2 - COORD_W'(1), c2 - COORD_W'(1),
				quad_sum[PIX_W+1:2], 1'b0});
		end
		if (row_pos != '0) begin
			pair_sum = (PIX_W+1)'(up) + (PIX_W+1)'(cur) + (PIX_W+1)'(1);
			zoom_q.push_back('{r2 - COORD_W'(1), c2, pair_sum[PIX_W:1], 1'b0});
		end
		if (col_pos != '0) begin
			pair_sum = (PIX_W+1)'(left_px) + (PIX_W+1)'(cur) + (PIX_W+1)'(1);
			zoom_q.push_back('{r2, c2 - COORD_W'(1), pair_sum[PIX_W:1], 1'b0});
		end
		zoom_q.push_back('{r2, c2, cur, 1'b1});

		row_mem[col_pos] = cur;
		diag_px = up;
		left_px = cur;

		// advance raster position; wrap at the end of the row and of the frame
		c_next = (COL_W+1)'(col_pos) + (COL_W+1)'(1);
		if (c_next >= w) begin
			col_pos = '0;
			r_next = (ROW_W+1)'(row_pos) + (ROW_W+1)'(1);
			if (r_next >= h)
				row_pos = '0;
			else
				row_pos = r_next[ROW_W-1:0];
		end else begin
			col_pos = c_next[COL_W-1:0];
		end
	endtask

	task automatic check_zoomed();
		zoom_px_t want;
		zoomed_seen++;
		if (zoom_q.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("[%0t] unexpected output pixel: row=%0d col=%0d value=%0d last=%0b",
					$time, out_row, out_col, out_value, run_last);
			return;
		end
		want = zoom_q.pop_front();
		if (out_row !== want.row || out_col !== want.col || out_value !== want.value ||
				run_last !== want.last) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display({"[%0t] mismatch: expected row=%0d col=%0d value=%0d last=%0b,",
					" got row=%0d col=%0d value=%0d last=%0b"},
					$time, want.row, want.col, want.value, want.last,
					out_row, out_col, out_value, run_last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = DIM_W'(MAX_WIDTH);
			height_reg = DIM_W'(MAX_HEIGHT);
			foreach (row_mem[i])
				row_mem[i] = '0;
			left_px = '0;
			diag_px = '0;
			row_pos = '0;
			col_pos = '0;
			zoom_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: width_reg = cfg_data;
					REG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				upscale_pixel(pixel_value);
			if (res_valid && !res_stall)
				check_zoomed();
			pending <= zoom_q.size();
		end
	end

endmodule

@@ tb/sv/tb_bilinear_upscale_2x_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_upscale_2x_unit
// Drives frames of grey pixels into the 2x upscaler under changing image
// sizes, with random gaps and stalls on both channels and one long output
// hold-off; the checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_bilinear_upscale_2x_unit;
	import bu2x_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_PIXELS   = 350;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TIMEOUT_NS      = 2_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	logic                 clk;
	logic                 arst_n;
	logic                 pix_valid;
	logic                 pix_stall;
	logic [PIX_W-1:0]     pixel_value;
	logic                 res_valid;
	logic                 res_stall;
	logic [COORD_W-1:0]   out_row;
	logic [COORD_W-1:0]   out_col;
	logic [PIX_W-1:0]     out_value;
	logic                 run_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	int pending;
	int fail_count;
	int zoomed_seen;

	logic idle_on;
	logic hold_off_req;
	logic hold_off_done;

	int eff_w;
	int eff_h;
	int pos_r;
	int pos_c;
	int pixels_sent;
	int frames_done;
	int reg_writes;
	int open_writes;

	bilinear_upscale_2x_unit dut (.*);

	bu2x_checker u_checker (.*);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d output pixels outstanding", pending);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// output side: random stalls, one long hold-off on request
	initial begin
		int stall_len;
		res_stall = 1'b0;
		hold_off_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
				res_stall <= 1'b0;
			end else begin
				stall_len = idle_on ? pick_gap() : 0;
				if (stall_len > 0) begin
					res_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
				res_stall <= 1'b0;
			end
		end
	end

	task automatic step_pos();
		pos_c++;
		if (pos_c >= eff_w) begin
			pos_c = 0;
			pos_r++;
			if (pos_r >= eff_h) begin
				pos_r = 0;
				frames_done++;
			end
		end
	endtask

	task automatic send_pixel(logic [PIX_W-1:0] v);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (pix_stall);
		pixels_sent++;
		step_pos();
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
		if (pos_r != 0 || pos_c != 0)
			open_writes++;
		case (idx)
			REG_IMAGE_WIDTH:
				eff_w = (int'(value) == 0) ? 1 :
					(int'(value) > MAX_WIDTH) ? MAX_WIDTH : int'(value);
			REG_IMAGE_HEIGHT:
				eff_h = (int'(value) == 0) ? 1 :
					(int'(value) > MAX_HEIGHT) ? MAX_HEIGHT : int'(value);
			default: ;
		endcase
	endtask

	task automatic finish_frame();
		while (pos_r != 0 || pos_c != 0)
			send_pixel(pick_pixel());
	endtask

	task automatic send_frame();
		send_pixel(pick_pixel());
		finish_frame();
	endtask

	initial begin
		int sel;
		int kind;
		int phase_no;
		int rand_target;
		logic [DIM_W-1:0] wide;

		arst_n = 1'b0;
		pix_valid = 1'b0;
		pixel_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		idle_on = 1'b0;
		hold_off_req = 1'b0;
		eff_w = MAX_WIDTH;
		eff_h = MAX_HEIGHT;
		pos_r = 0;
		pos_c = 0;
		pixels_sent = 0;
		frames_done = 0;
		reg_writes = 0;
		open_writes = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero width, saturated height: one column of vertical midpoints
		set_reg(REG_IMAGE_WIDTH, '0);
		set_reg(REG_IMAGE_HEIGHT, '1);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd128);
		// drop height below the current row: wrap at next advance
		set_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
		send_pixel(8'd1);
		set_reg(REG_SPARE, DIM_W'(11'h555));

		// full width, single row: horizontal midpoints and rounding
		set_reg(REG_IMAGE_WIDTH, '1);
		set_reg(REG_IMAGE_HEIGHT, DIM_W'(1));
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd254);
		send_pixel(8'd1);
		send_pixel(8'd255);
		send_pixel(8'd255);
		// drop width below the current column
		set_reg(REG_IMAGE_WIDTH, DIM_W'(3));
		send_pixel(8'd7);

		// 3x3 frame with centre points at the extremes
		set_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd255);
		send_pixel(8'd254);

		drain();
		idle_on <= 1'b1;
		rand_target = pixels_sent + RANDOM_PIXELS;
		phase_no = 0;
		while (pixels_sent < rand_target) begin
			kind = $urandom_range(0, 9);
			if (phase_no == 3) begin
				// hold the output long enough to back up the input
				set_reg(REG_IMAGE_WIDTH, DIM_W'(8));
				set_reg(REG_IMAGE_HEIGHT, DIM_W'(6));
				hold_off_req <= 1'b1;
				send_frame();
			end else if (kind == 0) begin
				sel = $urandom_range(0, 3);
				wide = (sel == 0) ? DIM_W'(MAX_WIDTH) : (sel == 1) ? '1 :
					DIM_W'($urandom_range(9, 2047));
				set_reg(REG_IMAGE_WIDTH, wide);
				set_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(0, 2047)));
				repeat ($urandom_range(4, 24)) send_pixel(pick_pixel());
				set_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(1, 6)));
				set_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 4)));
				finish_frame();
			end else if (kind <= 2) begin
				set_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(2, 8)));
				set_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(2, 6)));
				repeat ($urandom_range(1, eff_w * eff_h - 1)) send_pixel(pick_pixel());
				// width may only shrink while a frame is open
				if ($urandom_range(0, 1) == 0)
					set_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(1, eff_w)));
				else
					set_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 6)));
				finish_frame();
			end else begin
				sel = $urandom_range(0, 3);
				if (sel != 1)
					set_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(0, 8)));
				if (sel != 0)
					set_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(0, 6)));
				repeat ($urandom_range(1, 2)) send_frame();
			end
			phase_no++;
		end

		drain();
		$display("Upscaled %0d input pixels over %0d register writes (%0d with a frame open)",
			pixels_sent, reg_writes, open_writes);
		$display("Finished %0d frames, compared %0d output pixels, %0d failures",
			frames_done, zoomed_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bu2x_pkg.sv
hw/rtl/bu2x_line_buf.sv
hw/rtl/bu2x_interp.sv
hw/rtl/bu2x_emit.sv
hw/rtl/bilinear_upscale_2x_unit.sv
tb/sv/bu2x_checker.sv
tb/sv/tb_bilinear_upscale_2x_unit.sv
